[design/qdd_pkg.sv]
// Shared types, codes and the transition table for the quadrature detent decoder.
`timescale 1ns / 1ps

package qdd_pkg;

	// Field and state widths
	localparam int unsigned SamplesW = 4;
	localparam int unsigned LimitW   = 6;
	localparam int unsigned DetentW  = 4;
	localparam int unsigned PosW     = 7;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 6;

	// Item operation codes
	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_POLL   = 1'b1
	} op_t;

	// Reported detent direction
	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_CW   = 2'd1,
		DIR_CCW  = 2'd2
	} dir_t;

	// Register indexes
	localparam logic [CfgIdxW-1:0] REG_SAMPLES_REQUIRED  = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_COUNT_LIMIT       = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_COUNTS_PER_DETENT = 2'd2;

	// Register reset values
	localparam logic [SamplesW-1:0] SAMPLES_RESET = 4'd2;
	localparam logic [LimitW-1:0]   LIMIT_RESET   = 6'd20;
	localparam logic [DetentW-1:0]  DETENT_RESET  = 4'd4;

	typedef struct packed {
		logic [SamplesW-1:0] samples_required;
		logic [LimitW-1:0]   count_limit;
		logic [DetentW-1:0]  counts_per_detent;
	} cfg_t;

	typedef struct packed {
		logic [1:0]             accepted_state;
		logic [SamplesW-1:0]    mismatch_count;
		logic signed [PosW-1:0] position_count;
	} state_t;

	// Quarter-step direction for a move from state prev to state cur ({A,B})
	function automatic logic signed [1:0] step_dir(input logic [1:0] prev, input logic [1:0] cur);
		logic signed [1:0] d;
		d = 2'sd0;
		unique case ({prev, cur})
			4'b00_01, 4'b01_11, 4'b10_00, 4'b11_10: d = -2'sd1;
			4'b00_10, 4'b01_00, 4'b10_11, 4'b11_01: d = 2'sd1;
			default:                                d = 2'sd0;
		endcase
		return d;
	endfunction

endpackage

[design/qdd_cfg_regs.sv]
// Configuration register bank for the quadrature detent decoder.
`timescale 1ns / 1ps

module qdd_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [qdd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [qdd_pkg::CfgDataW-1:0] cfg_data,
	output qdd_pkg::cfg_t                cfg
);
	import qdd_pkg::*;

	cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.samples_required  <= SAMPLES_RESET;
			cfg_q.count_limit       <= LIMIT_RESET;
			cfg_q.counts_per_detent <= DETENT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SAMPLES_REQUIRED:  cfg_q.samples_required  <= cfg_data[SamplesW-1:0];
				REG_COUNT_LIMIT:       cfg_q.count_limit       <= cfg_data[LimitW-1:0];
				REG_COUNTS_PER_DETENT: cfg_q.counts_per_detent <= cfg_data[DetentW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/qdd_step.sv]
// Next-state and result logic for one sample or poll item.
`timescale 1ns / 1ps

module qdd_step (
	input  qdd_pkg::op_t   op,
	input  logic [1:0]     chan,
	input  qdd_pkg::cfg_t  cfg,
	input  qdd_pkg::state_t cur_state,
	output qdd_pkg::state_t nxt_state,
	output qdd_pkg::dir_t  dir
);
	import qdd_pkg::*;

	logic [SamplesW-1:0]     need;
	logic [SamplesW-1:0]     mism_inc;
	logic signed [PosW:0]    pos_w;
	logic signed [PosW:0]    moved;
	logic signed [PosW:0]    lim_w;
	logic signed [PosW:0]    det_w;
	logic signed [PosW-1:0]  clamped;

	// Operands widened by one bit so adds and negations cannot overflow
	assign need     = (cfg.samples_required == '0) ? SamplesW'(1) : cfg.samples_required;
	assign mism_inc = cur_state.mismatch_count + SamplesW'(1);
	assign pos_w    = {cur_state.position_count[PosW-1], cur_state.position_count};
	assign moved    = pos_w + (PosW+1)'(step_dir(cur_state.accepted_state, chan));
	assign lim_w    = $signed({{(PosW+1-LimitW){1'b0}}, cfg.count_limit});
	assign det_w    = (cfg.counts_per_detent == '0) ? (PosW+1)'(1)
	                : $signed({{(PosW+1-DetentW){1'b0}}, cfg.counts_per_detent});

	// Saturate the moved position at plus or minus the limit
	always_comb begin
		priority if (moved > lim_w) begin
			clamped = lim_w[PosW-1:0];
		end else if (moved < -lim_w) begin
			clamped = PosW'(-lim_w);
		end else begin
			clamped = moved[PosW-1:0];
		end
	end

	// Debounce on samples, detent take-off on polls
	always_comb begin
		nxt_state = cur_state;
		dir       = DIR_NONE;
		unique case (op)
			OP_SAMPLE: begin
				if (chan == cur_state.accepted_state) begin
					nxt_state.mismatch_count = '0;
				end else if (mism_inc >= need) begin
					nxt_state.mismatch_count = '0;
					nxt_state.position_count = clamped;
					nxt_state.accepted_state = chan;
				end else begin
					nxt_state.mismatch_count = mism_inc;
				end
			end
			OP_POLL: begin
				priority if (pos_w >= det_w) begin
					dir                      = DIR_CW;
					nxt_state.position_count = PosW'(pos_w - det_w);
				end else if (pos_w <= -det_w) begin
					dir                      = DIR_CCW;
					nxt_state.position_count = PosW'(pos_w + det_w);
				end else begin
					dir                      = DIR_NONE;
				end
			end
			default: ;
		endcase
	end

endmodule

[design/quadrature_decoder_detent_core.sv]
// Top level: input register, state update and result register.
// Path from input transfer to earliest result transfer: input register, then result register.
// Throughput: one item per cycle unless the output stalls; the qdd_step update is combinational.
// Back-pressure on the output stalls the input only when both registers are full.
// Reset (arst_n low, asynchronous): channel state 00, counts zero, registers to 2 / 20 / 4.
`timescale 1ns / 1ps

module quadrature_decoder_detent_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic                         operation,
	input  logic                         channel_a,
	input  logic                         channel_b,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   detent_direction,
	input  logic                         cfg_we,
	input  logic [qdd_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [qdd_pkg::CfgDataW-1:0] cfg_data
);
	import qdd_pkg::*;

	cfg_t   cfg;
	state_t state_q;
	state_t nxt_state;
	dir_t   dir;

	logic       valid_s1;
	op_t        op_s1;
	logic [1:0] chan_s1;
	logic       valid_s2;
	dir_t       dir_s2;
	logic       advance;

	qdd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	qdd_step u_step (
		.op        (op_s1),
		.chan      (chan_s1),
		.cfg       (cfg),
		.cur_state (state_q),
		.nxt_state (nxt_state),
		.dir       (dir)
	);

	// Stage 1 moves on when the result register is free or being drained
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1   <= op_t'(operation);
			chan_s1 <= {channel_a, channel_b};
		end
	end

	// Decoder state, updated as an item leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= nxt_state;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			dir_s2 <= dir;
		end
	end

	assign out_valid        = valid_s2;
	assign detent_direction = dir_s2;

	// A sample never reports a detent
	a_sample_no_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && op_s1 == OP_SAMPLE) |=> (detent_direction == DIR_NONE))
		else $error("sample produced a detent direction");

	// Position never reaches the one code outside plus or minus 63
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.position_count != -PosW'(64))
		else $error("position count out of range");

	// Mismatch count is cleared on reaching its target, so it never holds all ones
	a_mism_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.mismatch_count != '1)
		else $error("mismatch count overran");

	// State changes only when an item leaves stage 1
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && advance) |=> $stable(state_q))
		else $error("decoder state changed without an item");

	// A held result keeps the input register from overwriting it
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |=> (valid_s2 && $stable(dir_s2)))
		else $error("pending result lost");

endmodule

[sim/quadrature_decoder_detent_core_tb.sv]
// Self-checking testbench for the quadrature detent decoder core: scoreboard class and top.
`timescale 1ns / 1ps

import qdd_pkg::*;

// Tracks the decoder state and the detent directions still owed by the block
class detent_scoreboard;
	logic [SamplesW-1:0] samples_req;
	logic [LimitW-1:0]   limit;
	logic [DetentW-1:0]  per_detent;
	logic [1:0]          chan_state;
	logic [SamplesW-1:0] miss_count;
	int                  position;
	int                  quarter_tbl[4][4];
	dir_t                expected_dirs[$];
	int                  errors, transfers, checked, cw_seen, ccw_seen, moves;

	function new();
		// rows: old {A,B}, columns: new {A,B}
		quarter_tbl = '{'{0, -1, 1, 0}, '{1, 0, 0, -1}, '{-1, 0, 0, 1}, '{0, 1, -1, 0}};
		samples_req = SAMPLES_RESET;
		limit       = LIMIT_RESET;
		per_detent  = DETENT_RESET;
		chan_state  = 2'b00;
		miss_count  = '0;
		position    = 0;
		errors      = 0;
		transfers   = 0;
		checked     = 0;
		cw_seen     = 0;
		ccw_seen    = 0;
		moves       = 0;
	endfunction

	function void write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		case (idx)
			REG_SAMPLES_REQUIRED:  samples_req = data[SamplesW-1:0];
			REG_COUNT_LIMIT:       limit = data[LimitW-1:0];
			REG_COUNTS_PER_DETENT: per_detent = data[DetentW-1:0];
			default: ;
		endcase
	endfunction

	// A zero setting behaves as one
	function int need_count();
		return (samples_req == 0) ? 1 : int'(samples_req);
	endfunction

	// Advance the state by one accepted item and queue its detent direction
	function void note_transfer(input op_t op, input logic a, input logic b);
		logic [1:0] cur;
		int         lim, det, p;
		dir_t       dir;
		cur = {a, b};
		lim = int'(limit);
		det = (per_detent == 0) ? 1 : int'(per_detent);
		dir = DIR_NONE;
		transfers++;
		if (op == OP_SAMPLE) begin
			if (cur == chan_state) begin
				miss_count = '0;
			end else begin
				miss_count = miss_count + 1'b1;
				if (int'(miss_count) >= need_count()) begin
					miss_count = '0;
					p = position + quarter_tbl[chan_state][cur];
					if (p > lim)
						p = lim;
					else if (p < -lim)
						p = -lim;
					position   = p;
					chan_state = cur;
					moves++;
				end
			end
		end else if (position >= det) begin
			dir = DIR_CW;
			position -= det;
		end else if (position <= -det) begin
			dir = DIR_CCW;
			position += det;
		end
		expected_dirs.push_back(dir);
	endfunction

	function void check_result(input logic [1:0] got);
		dir_t want;
		checked++;
		if (expected_dirs.size() == 0) begin
			errors++;
			$display("%0t: detent_direction %0d with nothing expected", $time, got);
			return;
		end
		want = expected_dirs.pop_front();
		if (got !== want) begin
			errors++;
			$display("%0t: detent_direction expected %0d, actual %0d", $time, want, got);
		end else if (want == DIR_CW) begin
			cw_seen++;
		end else if (want == DIR_CCW) begin
			ccw_seen++;
		end
	endfunction
endclass

module quadrature_decoder_detent_core_tb;

	localparam int unsigned CYCLE_LIMIT  = 200_000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES  = 60;
	localparam int unsigned IDLE_PCT     = 14;
	localparam logic [CfgIdxW-1:0] REG_UNUSED = 2'd3;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                operation;
	logic                channel_a;
	logic                channel_b;
	logic                out_valid;
	logic                out_ready;
	logic [1:0]          detent_direction;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	detent_scoreboard sb;
	bit               idle_on;
	bit               hold_request;
	int               cycles = 0;
	int               settings;
	// shaft model for well-formed rotation: Gray index, samples left at it, direction
	int               shaft_pos;
	int               dwell_left;
	int               spin_dir;

	quadrature_decoder_detent_core i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.operation        (operation),
		.channel_a        (channel_a),
		.channel_b        (channel_b),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.detent_direction (detent_direction),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #10 clk = ~clk;

	// Run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Input transfers feed the scoreboard
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_transfer(op_t'(operation), channel_a, channel_b);
	end

	// Output transfers are checked in order
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(detent_direction);
	end

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	// Channel levels {A,B} for a Gray index; rising index is clockwise
	function automatic logic [1:0] gray(input int idx);
		case (idx & 3)
			0:       return 2'b00;
			1:       return 2'b10;
			2:       return 2'b11;
			default: return 2'b01;
		endcase
	endfunction

	task automatic send_item(input op_t op, input logic a, input logic b);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		operation <= op;
		channel_a <= a;
		channel_b <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_sample(input logic [1:0] ab);
		send_item(OP_SAMPLE, ab[1], ab[0]);
	endtask

	// Channel levels are don't-care on a poll, so randomize them
	task automatic send_poll();
		send_item(OP_POLL, 1'($urandom_range(1)), 1'($urandom_range(1)));
	endtask

	// Wait until every owed result has come out and the pipeline is empty
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_dirs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Upper data bits of the narrow registers are set at random; they must be dropped
	task automatic configure(input int req, input int lim, input int det);
		settle();
		write_reg(REG_SAMPLES_REQUIRED, {2'($urandom_range(3)), 4'(req)});
		write_reg(REG_COUNT_LIMIT, 6'(lim));
		write_reg(REG_COUNTS_PER_DETENT, {2'($urandom_range(3)), 4'(det)});
		settings++;
	endtask

	// Clean rotation: each quarter step held just long enough to be taken
	task automatic spin(input int steps, input int dir);
		repeat (steps) begin
			shaft_pos += dir;
			repeat (sb.need_count()) send_sample(gray(shaft_pos));
		end
	endtask

	// Mostly debounced rotation with random dwell and reversals, plus polls,
	// single-sample bounces and arbitrary channel noise
	task automatic run_random(input int n);
		int r;
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 18) begin
				send_poll();
			end else if (r < 26) begin
				send_item(OP_SAMPLE, 1'($urandom_range(1)), 1'($urandom_range(1)));
			end else begin
				if (dwell_left <= 0) begin
					shaft_pos += spin_dir;
					dwell_left = sb.need_count() + $urandom_range(2);
					if ($urandom_range(9) == 0)
						spin_dir = -spin_dir;
				end
				if ($urandom_range(19) == 0) begin
					send_sample(gray(shaft_pos + spin_dir));
				end else begin
					send_sample(gray(shaft_pos));
					dwell_left--;
				end
			end
		end
	endtask

	// Main sequence
	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		operation    = OP_SAMPLE;
		channel_a    = 1'b0;
		channel_b    = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_SAMPLES_REQUIRED;
		cfg_data     = '0;
		idle_on      = 1'b1;
		hold_request = 1'b0;
		settings     = 1;
		shaft_pos    = 0;
		dwell_left   = 0;
		spin_dir     = 1;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at reset settings (two samples, limit 20, detent 4)
		send_poll();
		// equal sample clears a pending mismatch
		send_sample(2'b00); send_sample(2'b10); send_sample(2'b00);
		// two differing samples that differ from each other; jump across two states
		send_sample(2'b10); send_sample(2'b11);
		// clockwise to four quarter steps, then one detent
		send_sample(2'b01); send_sample(2'b01); send_sample(2'b00); send_sample(2'b00);
		send_sample(2'b10); send_sample(2'b10); send_sample(2'b11); send_sample(2'b11);
		send_poll(); send_poll();
		// counter-clockwise back down to one detent
		send_sample(2'b10); send_sample(2'b10); send_sample(2'b00); send_sample(2'b00);
		send_sample(2'b01); send_sample(2'b01); send_sample(2'b11); send_sample(2'b11);
		send_poll();
		shaft_pos = 2;

		// All-zero registers; unknown index must be ignored
		configure(0, 0, 0);
		write_reg(REG_UNUSED, 6'($urandom_range(63)));
		run_random(60);

		// Widest limit, single sample, largest detent; long stretch with no idling
		configure(1, 63, 15);
		idle_on = 1'b0;
		spin(70, 1);
		run_random(30);
		spin(20, 1);

		// Limit lowered under a saturated position: polls see the old count
		configure(3, 5, 1);
		idle_on = 1'b1;
		repeat (8) send_poll();
		hold_request = 1'b1;
		run_random(80);

		// Slowest debounce, limit of one
		configure(15, 1, 15);
		run_random(80);

		// Negative saturation
		configure(1, 63, 2);
		spin(70, -1);
		run_random(60);

		// Back to reset values, then random settings
		configure(SAMPLES_RESET, LIMIT_RESET, DETENT_RESET);
		run_random(50);
		repeat (2) begin
			configure($urandom_range(15), $urandom_range(63), $urandom_range(15));
			run_random(40);
		end

		settle();
		$display("Covered %0d input transfers and %0d results over %0d register settings.",
			sb.transfers, sb.checked, settings);
		$display("Saw %0d clockwise and %0d counter-clockwise detents, %0d accepted moves.",
			sb.cw_seen, sb.ccw_seen, sb.moves);
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

[sim.f]
design/qdd_pkg.sv
design/qdd_cfg_regs.sv
design/qdd_step.sv
design/quadrature_decoder_detent_core.sv
sim/quadrature_decoder_detent_core_tb.sv
